[rtl/dtoi_pkg.sv]
package dtoi_pkg;

	localparam logic [7:0] CH_PLUS  = 8'h2B;
	localparam logic [7:0] CH_MINUS = 8'h2D;
	localparam logic [7:0] CH_ZERO  = 8'h30;
	localparam logic [7:0] CH_NINE  = 8'h39;

	localparam logic [4:0] LEN_NARROW = 5'd11;
	localparam logic [4:0] LEN_WIDE   = 5'd20;
	localparam logic [4:0] POS_MAX    = 5'd31;

	localparam logic [63:0] HALF_NARROW = 64'h0000_0000_8000_0000;
	localparam logic [63:0] HALF_WIDE   = 64'h8000_0000_0000_0000;

	typedef enum logic [1:0] {
		ERR_NONE     = 2'd0,
		ERR_BAD_CHAR = 2'd1,
		ERR_TOO_LONG = 2'd2,
		ERR_OVERFLOW = 2'd3
	} err_kind_t;

	typedef struct packed {
		logic [63:0] magnitude;
		logic        negative;
		logic [4:0]  position;
		logic        first_is_sign;
		err_kind_t   sticky;
	} dtoi_state_t;

	typedef struct packed {
		logic        ok;
		logic [63:0] value;
		err_kind_t   kind;
	} dtoi_result_t;

endpackage

[rtl/dtoi_core.sv]
module dtoi_core import dtoi_pkg::*; (
	input  dtoi_state_t  cur,
	input  logic [7:0]   char_code,
	input  logic         last_char,
	input  logic         wide,
	output dtoi_state_t  nxt,
	output dtoi_result_t res
);

	logic        is_sign;
	logic        is_digit;
	logic [3:0]  digit;
	logic [63:0] half;
	logic [63:0] lim_step;
	logic [63:0] lim_final;
	logic [67:0] scaled;
	logic        step_ovf;
	logic        neg_n;
	logic        first_n;
	logic [63:0] mag_n;
	logic [4:0]  pos_n;
	logic [4:0]  len_limit;
	err_kind_t   sticky_n;
	err_kind_t   kind;

	assign is_sign  = (cur.position == 5'd0) && ((char_code == CH_MINUS) || (char_code == CH_PLUS));
	assign is_digit = (char_code >= CH_ZERO) && (char_code <= CH_NINE);
	assign digit    = 4'(char_code - CH_ZERO);
	assign half     = wide ? HALF_WIDE : HALF_NARROW;

	// m*10 + d in 68 bits so the compare sees the true value before any wrap
	assign lim_step = half - {63'd0, ~cur.negative};
	assign scaled   = {1'b0, cur.magnitude, 3'b000} + {3'b000, cur.magnitude, 1'b0}
	                + {64'd0, digit};
	assign step_ovf = scaled > {4'd0, lim_step};

	always_comb begin
		neg_n    = cur.negative;
		first_n  = cur.first_is_sign;
		mag_n    = cur.magnitude;
		sticky_n = cur.sticky;
		if (is_sign) begin
			first_n = 1'b1;
			neg_n   = (char_code == CH_MINUS);
		end else if (is_digit) begin
			if (cur.sticky == ERR_NONE) begin
				if (step_ovf) sticky_n = ERR_OVERFLOW;
				else mag_n = scaled[63:0];
			end
		end else begin
			sticky_n = ERR_BAD_CHAR;
		end
	end

	assign pos_n     = (cur.position < POS_MAX) ? cur.position + 5'd1 : cur.position;
	assign len_limit = wide ? LEN_WIDE : LEN_NARROW;
	assign lim_final = half - {63'd0, ~neg_n};

	// recheck the magnitude against the current width and apply the length limit at the end of the string
	always_comb begin
		kind = sticky_n;
		if (kind == ERR_NONE && mag_n > lim_final) kind = ERR_OVERFLOW;
		if (pos_n > len_limit || (pos_n == len_limit && !first_n)) kind = ERR_TOO_LONG;
	end

	always_comb begin
		res.ok    = (kind == ERR_NONE);
		res.kind  = kind;
		res.value = 64'd0;
		if (kind == ERR_NONE) res.value = neg_n ? (64'd0 - mag_n) : mag_n;
	end

	always_comb begin
		if (last_char) begin
			nxt = '0;
		end else begin
			nxt.magnitude     = mag_n;
			nxt.negative      = neg_n;
			nxt.position      = pos_n;
			nxt.first_is_sign = first_n;
			nxt.sticky        = sticky_n;
		end
	end

endmodule

[rtl/decimal_text_to_integer_unit.sv]
// Streaming decimal text to signed integer converter. Characters arrive one
// per transaction on the char channel, the final one flagged by last_char; an
// optional leading '+' or '-' is followed by digits only. One character is
// taken every clock cycle with no bubbles between strings; only a last
// character waits on a stalled result. The rate is set by the magnitude
// register loop: one 64-bit multiply-by-ten, add and limit compare per
// cycle. Each string yields one result transaction, registered once the
// result channel is free. wide_mode (reset 1) picks a 64-bit result with a
// 20-character limit, or a 32-bit result with an 11-character limit; the
// full length is allowed only with a leading sign. On error ok is 0, value
// is 0 and error_kind gives bad character (1), too long (2) or overflow (3).
// Write wide_mode only while no string is in flight.
module decimal_text_to_integer_unit import dtoi_pkg::*; (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               wide_mode_we,
	input  logic               wide_mode_wdata,
	input  logic               char_valid,
	output logic               char_stall,
	input  logic [7:0]         char_code,
	input  logic               last_char,
	output logic               result_valid,
	input  logic               result_stall,
	output logic               ok,
	output logic signed [63:0] value,
	output logic [1:0]         error_kind
);

	logic         wide_mode_q;
	dtoi_state_t  state_q;
	dtoi_state_t  state_n;
	dtoi_result_t res;
	logic         valid_s1;
	logic [7:0]   char_s1;
	logic         last_s1;
	logic         result_valid_q;
	dtoi_result_t result_q;
	logic         out_free;
	logic         consume_s1;
	logic         load_s1;

	assign out_free   = !result_valid_q || !result_stall;
	assign consume_s1 = valid_s1 && (!last_s1 || out_free);
	assign char_stall = valid_s1 && !consume_s1;
	assign load_s1    = char_valid && !char_stall;

	dtoi_core u_core (
		.cur       (state_q),
		.char_code (char_s1),
		.last_char (last_s1),
		.wide      (wide_mode_q),
		.nxt       (state_n),
		.res       (res)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wide_mode_q <= 1'b1;
		end else if (wide_mode_we) begin
			wide_mode_q <= wide_mode_wdata;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1       <= 1'b0;
			state_q        <= '0;
			result_valid_q <= 1'b0;
		end else begin
			if (load_s1) valid_s1 <= 1'b1;
			else if (consume_s1) valid_s1 <= 1'b0;
			if (consume_s1) state_q <= state_n;
			if (consume_s1 && last_s1) result_valid_q <= 1'b1;
			else if (!result_stall) result_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (load_s1) begin
			char_s1 <= char_code;
			last_s1 <= last_char;
		end
		if (consume_s1 && last_s1) result_q <= res;
	end

	assign result_valid = result_valid_q;
	assign ok           = result_q.ok;
	assign value        = result_q.value;
	assign error_kind   = result_q.kind;

endmodule

[rtl/dtoi_checker.sv]
module dtoi_checker (
	input logic        clk,
	input logic        arst_n,
	input logic        result_valid,
	input logic        result_stall,
	input logic        ok,
	input logic [63:0] value,
	input logic [1:0]  error_kind
);

	// hold a stalled result transaction
	a_result_hold: assert property (@(posedge clk) disable iff (!arst_n)
		result_valid && result_stall |=> result_valid && $stable(value)
		&& $stable(ok) && $stable(error_kind))
		else $error("stalled result changed");

	a_ok_no_error: assert property (@(posedge clk) disable iff (!arst_n)
		result_valid && ok |-> error_kind == 2'd0)
		else $error("ok result carries an error code");

	a_error_zero: assert property (@(posedge clk) disable iff (!arst_n)
		result_valid && !ok |-> error_kind != 2'd0 && value == 64'd0)
		else $error("failed result has no code or a nonzero value");

endmodule

bind decimal_text_to_integer_unit dtoi_checker u_dtoi_checker (
	.clk          (clk),
	.arst_n       (arst_n),
	.result_valid (result_valid),
	.result_stall (result_stall),
	.ok           (ok),
	.value        (value),
	.error_kind   (error_kind)
);

[dv/integer_conversion_checker.sv]
`timescale 1ns / 1ps

module integer_conversion_checker import dtoi_pkg::*; (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               wide_mode_we,
	input  logic               wide_mode_wdata,
	input  logic               char_valid,
	input  logic               char_stall,
	input  logic [7:0]         char_code,
	input  logic               last_char,
	input  logic               result_valid,
	input  logic               result_stall,
	input  logic               ok,
	input  logic signed [63:0] value,
	input  logic [1:0]         error_kind,
	output int                 fail_count,
	output int                 outstanding,
	output int                 results_checked
);

	logic         width_sel;
	dtoi_state_t  conv;
	dtoi_result_t conversions_due[$];

	initial begin
		fail_count = 0;
		outstanding = 0;
		results_checked = 0;
	end

	// Largest magnitude that fits the selected width with the given sign.
	function automatic logic [63:0] mag_ceiling(input logic wide, input logic neg);
		logic [63:0] half;
		half = wide ? HALF_WIDE : HALF_NARROW;
		return neg ? half : half - 64'd1;
	endfunction

	always @(posedge clk or negedge arst_n) begin
		logic [7:0]   c;
		logic [63:0]  digit;
		logic [4:0]   span;
		err_kind_t    kind;
		dtoi_result_t want;
		if (!arst_n) begin
			width_sel = 1'b1;
			conv = '0;
			conversions_due.delete();
			outstanding <= 0;
		end else begin
			if (result_valid && !result_stall) begin
				if (conversions_due.size() == 0) begin
					if (fail_count < 10)
						$display("Unexpected result transaction: ok=%0b value=%0d kind=%0d",
							ok, value, error_kind);
					fail_count++;
				end else begin
					want = conversions_due.pop_front();
					results_checked++;
					if (want.ok !== ok || want.value !== value || want.kind !== error_kind) begin
						if (fail_count < 10)
							$display({"Mismatch: expected ok=%0b value=%0d kind=%0d, ",
								"got ok=%0b value=%0d kind=%0d"},
								want.ok, $signed(want.value), want.kind,
								ok, value, error_kind);
						fail_count++;
					end
				end
			end

			if (char_valid && !char_stall) begin
				c = char_code;
				if (conv.position == 5'd0 && (c == CH_MINUS || c == CH_PLUS)) begin
					conv.first_is_sign = 1'b1;
					conv.negative = (c == CH_MINUS);
				end else if (c >= CH_ZERO && c <= CH_NINE) begin
					// stop accumulating once any error is recorded
					if (conv.sticky == ERR_NONE) begin
						digit = {56'd0, c - CH_ZERO};
						if (conv.magnitude > (mag_ceiling(width_sel, conv.negative) - digit) / 64'd10)
							conv.sticky = ERR_OVERFLOW;
						else
							conv.magnitude = conv.magnitude * 64'd10 + digit;
					end
				end else begin
					conv.sticky = ERR_BAD_CHAR;
				end
				if (conv.position != POS_MAX)
					conv.position = conv.position + 5'd1;

				if (last_char) begin
					kind = conv.sticky;
					span = width_sel ? LEN_WIDE : LEN_NARROW;
					if (kind == ERR_NONE && conv.magnitude > mag_ceiling(width_sel, conv.negative))
						kind = ERR_OVERFLOW;
					// length error outranks everything
					if (conv.position > span || (conv.position == span && !conv.first_is_sign))
						kind = ERR_TOO_LONG;
					want.ok = (kind == ERR_NONE);
					want.kind = kind;
					if (kind == ERR_NONE)
						want.value = conv.negative ? 64'd0 - conv.magnitude : conv.magnitude;
					else
						want.value = '0;
					conversions_due.push_back(want);
					conv = '0;
				end
			end

			if (wide_mode_we)
				width_sel = wide_mode_wdata;

			outstanding <= conversions_due.size();
		end
	end

endmodule

[dv/decimal_text_to_integer_unit_tb.sv]
`timescale 1ns / 1ps

module decimal_text_to_integer_unit_tb import dtoi_pkg::*; ;

	localparam int CYCLE_LIMIT = 400000;

	typedef enum int {SIGN_NONE, SIGN_PLUS, SIGN_MINUS} sign_t;
	typedef enum int {STALL_NONE, STALL_HALF, STALL_HEAVY, STALL_LIGHT} stall_mode_t;

	logic               clk = 1'b0;
	logic               arst_n = 1'b0;
	logic               wide_mode_we = 1'b0;
	logic               wide_mode_wdata = 1'b0;
	logic               char_valid = 1'b0;
	logic               char_stall;
	logic [7:0]         char_code = 8'd0;
	logic               last_char = 1'b0;
	logic               result_valid;
	logic               result_stall = 1'b0;
	logic               ok;
	logic signed [63:0] value;
	logic [1:0]         error_kind;

	int fail_count;
	int outstanding;
	int results_checked;

	int          cycle_count = 0;
	int          chars_sent = 0;
	int          strings_sent = 0;
	int          burst_left = 0;
	logic        wide_now = 1'b1;
	stall_mode_t stall_mode = STALL_NONE;
	int          stall_hold = 0;
	logic [7:0]  text_q[$];

	decimal_text_to_integer_unit u_top (
		.clk             (clk),
		.arst_n          (arst_n),
		.wide_mode_we    (wide_mode_we),
		.wide_mode_wdata (wide_mode_wdata),
		.char_valid      (char_valid),
		.char_stall      (char_stall),
		.char_code       (char_code),
		.last_char       (last_char),
		.result_valid    (result_valid),
		.result_stall    (result_stall),
		.ok              (ok),
		.value           (value),
		.error_kind      (error_kind)
	);

	integer_conversion_checker u_checker (
		.clk             (clk),
		.arst_n          (arst_n),
		.wide_mode_we    (wide_mode_we),
		.wide_mode_wdata (wide_mode_wdata),
		.char_valid      (char_valid),
		.char_stall      (char_stall),
		.char_code       (char_code),
		.last_char       (last_char),
		.result_valid    (result_valid),
		.result_stall    (result_stall),
		.ok              (ok),
		.value           (value),
		.error_kind      (error_kind),
		.fail_count      (fail_count),
		.outstanding     (outstanding),
		.results_checked (results_checked)
	);

	always begin
		clk = 1'b0;
		#10;
		clk = 1'b1;
		#10;
	end

	always @(posedge clk) begin
		cycle_count++;
		if (cycle_count == CYCLE_LIMIT) begin
			$display("Run timed out after %0d cycles", cycle_count);
			$display("Verification failed");
			$finish;
		end
	end

	// Result side: switch among stall patterns every so often.
	always @(posedge clk) begin
		if (stall_hold == 0) begin
			stall_mode = stall_mode_t'($urandom_range(0, 3));
			stall_hold = $urandom_range(20, 150);
		end else begin
			stall_hold--;
		end
		case (stall_mode)
			STALL_NONE:  result_stall <= 1'b0;
			STALL_HALF:  result_stall <= ($urandom_range(0, 1) == 1);
			STALL_HEAVY: result_stall <= ($urandom_range(0, 7) != 0);
			default:     result_stall <= ($urandom_range(0, 3) == 0);
		endcase
	end

	// Send one character; hold it until the transaction is taken.
	task automatic push_char(input logic [7:0] c, input logic fin);
		int gap;
		if (burst_left == 0) begin
			burst_left = $urandom_range(1, 40);
			gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 8);
			if (gap != 0) begin
				char_valid <= 1'b0;
				repeat (gap) @(posedge clk);
			end
		end
		burst_left--;
		char_valid <= 1'b1;
		char_code <= c;
		last_char <= fin;
		@(posedge clk);
		while (char_stall) @(posedge clk);
		chars_sent++;
	endtask

	task automatic send_text();
		for (int i = 0; i < text_q.size(); i++)
			push_char(text_q[i], i == text_q.size() - 1);
		strings_sent++;
		text_q.delete();
	endtask

	task automatic add_str(input string s);
		for (int i = 0; i < s.len(); i++)
			text_q.push_back(s[i]);
	endtask

	task automatic send_str(input string s);
		add_str(s);
		send_text();
	endtask

	task automatic add_sign(input sign_t s);
		if (s == SIGN_PLUS)
			text_q.push_back(CH_PLUS);
		else if (s == SIGN_MINUS)
			text_q.push_back(CH_MINUS);
	endtask

	task automatic add_digits(input int n);
		for (int i = 0; i < n; i++)
			text_q.push_back(CH_ZERO + 8'($urandom_range(0, 9)));
	endtask

	// Hold off the sender until every conversion has come back, then settle.
	task automatic drain();
		char_valid <= 1'b0;
		burst_left = 0;
		@(posedge clk);
		while (outstanding != 0) @(posedge clk);
		repeat (4) @(posedge clk);
	endtask

	task automatic set_width(input logic w);
		drain();
		wide_mode_we <= 1'b1;
		wide_mode_wdata <= w;
		@(posedge clk);
		wide_mode_we <= 1'b0;
		wide_now = w;
	endtask

	task automatic make_random_text();
		int          pick;
		int          n;
		int          span;
		int          spot;
		sign_t       sgn;
		logic [63:0] mag;
		span = wide_now ? 20 : 11;
		pick = $urandom_range(0, 99);
		sgn = sign_t'($urandom_range(0, 2));
		if (pick < 45) begin
			// well-formed, random length up to the limit
			add_sign(sgn);
			n = $urandom_range((sgn == SIGN_NONE) ? 1 : 0, span - 1);
			add_digits(n);
		end else if (pick < 65) begin
			// magnitudes around the edges of the range
			mag = (wide_now ? HALF_WIDE : HALF_NARROW) - 64'd3 + 64'($urandom_range(0, 6));
			add_sign(sgn);
			add_str($sformatf("%0d", mag));
		end else if (pick < 80) begin
			// corrupt one character of a well-formed string
			add_sign(sgn);
			add_digits($urandom_range(1, span - 2));
			spot = $urandom_range(0, text_q.size() - 1);
			case ($urandom_range(0, 2))
				0:       text_q[spot] = CH_MINUS;
				1:       text_q[spot] = CH_PLUS;
				default: text_q[spot] = 8'($urandom_range(0, 255));
			endcase
		end else if (pick < 90) begin
			// exactly the limit without a sign, or past it
			if ($urandom_range(0, 1) == 0) begin
				add_digits(span);
			end else begin
				add_sign(sgn);
				add_digits($urandom_range(span, 34));
			end
		end else begin
			n = $urandom_range(1, 6);
			for (int i = 0; i < n; i++)
				text_q.push_back(8'($urandom_range(0, 255)));
		end
	endtask

	initial begin
		int  target;
		bit  paused;
		paused = 0;
		repeat (6) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// 64-bit mode straight out of reset
		send_str("0");
		send_str("+");
		send_str("-");
		send_str("-9223372036854775808");
		send_str("+9223372036854775807");
		send_str("9223372036854775807");
		send_str("9223372036854775808");
		send_str("-9223372036854775809");
		send_str("+9999999999999999999");
		send_str("12a4");
		send_str("1-2");
		send_str("00000000000000000001");
		send_str("+000000000000000000001");

		set_width(1'b0);
		send_str("-2147483648");
		send_str("+2147483647");
		send_str("2147483647");
		send_str("2147483648");
		send_str("-2147483649");
		send_str("12345678901");
		send_str("+1234567890");
		send_str("-0");
		send_str("+-1");
		text_q.push_back(8'h00);
		add_str("5");
		send_text();
		add_str("3");
		text_q.push_back(8'hFF);
		send_text();

		for (int p = 0; p < 4; p++) begin
			set_width(p % 2 == 1);
			target = chars_sent + 340;
			while (chars_sent < target) begin
				if (!paused && p == 1 && chars_sent > target - 200) begin
					drain();
					paused = 1;
				end
				make_random_text();
				send_text();
			end
		end

		drain();
		repeat (10) @(posedge clk);
		$display("Sent %0d strings (%0d characters) across both widths; %0d results checked",
			strings_sent, chars_sent, results_checked);
		if (fail_count == 0)
			$display("Verification passed");
		else
			$display("Verification failed");
		$finish;
	end

endmodule

[decimal_text_to_integer_unit.f]
rtl/dtoi_pkg.sv
rtl/dtoi_core.sv
rtl/decimal_text_to_integer_unit.sv
rtl/dtoi_checker.sv
dv/integer_conversion_checker.sv
dv/decimal_text_to_integer_unit_tb.sv
